// ===== hw/rtl/imminence_victim_selector_top_macros.svh =====
// ----------------------------------------------------------------------------
// imminence victim selector assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in rst
// ----------------------------------------------------------------------------
`ifndef IMMINENCE_VICTIM_SELECTOR_TOP_MACROS_SVH
`define IMMINENCE_VICTIM_SELECTOR_TOP_MACROS_SVH

// same-cycle implication
`define IVS_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ivs assertion failed");

// next-cycle implication
`define IVS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ivs assertion failed");

`endif

// ===== hw/rtl/ivs_pkg.sv =====
// ----------------------------------------------------------------------------
// ivs_pkg
// request codes, classified command and result types for the victim selector
// ----------------------------------------------------------------------------
package ivs_pkg;

  localparam int WAY_IN_W = 3;
  localparam int COL_IN_W = 2;
  localparam int COUNT_W  = 9;

  // request codes on the req_type port
  localparam logic [2:0] REQ_FRONT   = 3'd0;
  localparam logic [2:0] REQ_BACK    = 3'd1;
  localparam logic [2:0] REQ_WRITE   = 3'd2;
  localparam logic [2:0] REQ_ADVANCE = 3'd3;
  localparam logic [2:0] REQ_RETREAT = 3'd4;
  localparam logic [2:0] REQ_SELECT  = 3'd5;

  localparam logic signed [COUNT_W-1:0] COUNT_EMPTY = -9'sd1;
  localparam logic signed [COUNT_W-1:0] COUNT_FLOOR = -9'sd2;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_FRONT,
    OP_BACK,
    OP_WRITE,
    OP_ADVANCE,
    OP_RETREAT,
    OP_SELECT
  } op_t;

  typedef struct packed {
    op_t                        op;
    logic [WAY_IN_W-1:0]        way;
    logic [COL_IN_W-1:0]        column;
    logic signed [COUNT_W-1:0]  count;
  } cmd_t;

  typedef struct packed {
    logic [WAY_IN_W-1:0]        victim_way;
    logic signed [COUNT_W-1:0]  victim_count;
    logic [COL_IN_W-1:0]        current_column;
  } res_t;

endpackage

// ===== hw/rtl/imminence_victim_selector_top.sv =====
// a move, count write or column step passes through the command queue and the back into the result queue
// select: the count store read port visits one way per cycle, up to the first empty count or the last way
// throughput: one non-select request per cycle while neither queue is full, a select holds the back until its scan ends
// reset: recency order to identity, column pointer to 0, then a clearing pass writes empty counts
// to all WAYS*COLUMNS count entries (32 at defaults) with full held high
// ----------------------------------------------------------------------------
// imminence_victim_selector_top
// replacement victim selector for one cache set, front/queue/back organization
// ----------------------------------------------------------------------------
module imminence_victim_selector_top #(
  parameter int WAYS    = 8,
  parameter int COLUMNS = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic [2:0]                          req_type,
  input  logic [ivs_pkg::WAY_IN_W-1:0]        way,
  input  logic [ivs_pkg::COL_IN_W-1:0]        column,
  input  logic signed [ivs_pkg::COUNT_W-1:0]  count_value,
  output logic                                empty,
  input  logic                                pop,
  output logic [ivs_pkg::WAY_IN_W-1:0]        victim_way,
  output logic signed [ivs_pkg::COUNT_W-1:0]  victim_count,
  output logic [ivs_pkg::COL_IN_W-1:0]        current_column
);

  import ivs_pkg::*;

  localparam int CMD_W = $bits(cmd_t);
  localparam int RES_W = $bits(res_t);

  cmd_t             front_cmd;
  logic             front_valid;
  logic             q_full;
  logic             q_empty;
  logic [CMD_W-1:0] q_bits;
  cmd_t             q_cmd;
  logic             q_pop;
  logic             clearing;
  logic             res_full;
  logic             res_push;
  res_t             back_res;
  logic [RES_W-1:0] out_bits;
  res_t             out_res;

  ivs_front #(
    .WAYS    (WAYS),
    .COLUMNS (COLUMNS)
  ) u_front (
    .push        (push),
    .full        (full),
    .req_type    (req_type),
    .way         (way),
    .column      (column),
    .count_value (count_value),
    .q_full      (q_full),
    .clearing    (clearing),
    .cmd_valid   (front_valid),
    .cmd         (front_cmd)
  );

  ivs_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (2)
  ) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (front_valid),
    .wr_data (front_cmd),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_bits),
    .empty   (q_empty)
  );

  assign q_cmd = cmd_t'(q_bits);

  ivs_back #(
    .WAYS    (WAYS),
    .COLUMNS (COLUMNS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (q_empty),
    .cmd       (q_cmd),
    .cmd_pop   (q_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (back_res),
    .clearing  (clearing)
  );

  ivs_fifo #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (back_res),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (out_bits),
    .empty   (empty)
  );

  assign out_res        = res_t'(out_bits);
  assign victim_way     = out_res.victim_way;
  assign victim_count   = out_res.victim_count;
  assign current_column = out_res.current_column;

endmodule

// ===== hw/rtl/ivs_fifo.sv =====
// ----------------------------------------------------------------------------
// ivs_fifo
// small synchronous queue used between the front and back and for results
// ----------------------------------------------------------------------------
module ivs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push_ok;
  logic             pop_ok;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign push_ok = wr_en && !full;
  assign pop_ok  = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push_ok, pop_ok})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

// ===== hw/rtl/ivs_front.sv =====
// ----------------------------------------------------------------------------
// ivs_front
// accepts request beats, range-checks them and turns them into commands
// ----------------------------------------------------------------------------
module ivs_front #(
  parameter int WAYS    = 8,
  parameter int COLUMNS = 4
) (
  input  logic                                push,
  output logic                                full,
  input  logic [2:0]                          req_type,
  input  logic [ivs_pkg::WAY_IN_W-1:0]        way,
  input  logic [ivs_pkg::COL_IN_W-1:0]        column,
  input  logic signed [ivs_pkg::COUNT_W-1:0]  count_value,
  input  logic                                q_full,
  input  logic                                clearing,
  output logic                                cmd_valid,
  output ivs_pkg::cmd_t                       cmd
);

  import ivs_pkg::*;

  logic way_ok;
  logic col_ok;

  assign way_ok    = (32'(way) < 32'(WAYS));
  assign col_ok    = (32'(column) < 32'(COLUMNS));
  assign full      = q_full || clearing;
  assign cmd_valid = push && !full;

  always_comb begin
    cmd.way    = way;
    cmd.column = column;
    cmd.count  = count_value;
    case (req_type)
      REQ_FRONT:   cmd.op = way_ok ? OP_FRONT : OP_NOP;
      REQ_BACK:    cmd.op = way_ok ? OP_BACK : OP_NOP;
      REQ_WRITE:   cmd.op = (way_ok && col_ok) ? OP_WRITE : OP_NOP;
      REQ_ADVANCE: cmd.op = OP_ADVANCE;
      REQ_RETREAT: cmd.op = OP_RETREAT;
      REQ_SELECT:  cmd.op = OP_SELECT;
      default:     cmd.op = OP_NOP;
    endcase
  end

endmodule

// ===== hw/rtl/ivs_back.sv =====
// ----------------------------------------------------------------------------
// ivs_back
// executes commands: recency moves, count store, column pointer, victim scan
// ----------------------------------------------------------------------------
`include "imminence_victim_selector_top_macros.svh"

module ivs_back #(
  parameter int WAYS    = 8,
  parameter int COLUMNS = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_empty,
  input  ivs_pkg::cmd_t cmd,
  output logic          cmd_pop,
  input  logic          res_full,
  output logic          res_push,
  output ivs_pkg::res_t res,
  output logic          clearing
);

  import ivs_pkg::*;

  localparam int WAY_W     = $clog2(WAYS);
  localparam int COL_W     = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int MEM_DEPTH = WAYS * COLUMNS;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;

  logic [1:0]                state;
  logic [1:0]                state_next;
  logic [WAY_W-1:0]          order [WAYS];
  logic [WAY_W-1:0]          order_next [WAYS];
  logic [WAY_W-1:0]          order_front [WAYS];
  logic [WAY_W-1:0]          order_back [WAYS];
  logic [COL_W-1:0]          col_ptr;
  logic [COL_W-1:0]          col_ptr_next;
  logic [ADDR_W-1:0]         clr_cnt;
  logic [ADDR_W-1:0]         clr_cnt_next;

  logic signed [COUNT_W-1:0] mem [MEM_DEPTH];
  logic                      mem_we;
  logic [ADDR_W-1:0]         wr_addr;
  logic signed [COUNT_W-1:0] wr_data;
  logic [ADDR_W-1:0]         rd_addr;
  logic signed [COUNT_W-1:0] rd_data;

  logic                      take;
  logic [WAY_W-1:0]          cmd_way;
  logic [COL_W-1:0]          cmd_col;
  logic [WAY_W-1:0]          hit_pos;

  logic [WAY_W-1:0]          scan_pos;
  logic [WAY_W-1:0]          nxt_pos;
  logic [WAY_W-1:0]          rd_pos;
  logic signed [COUNT_W-1:0] best;
  logic signed [COUNT_W-1:0] best_n;
  logic [WAY_W-1:0]          best_way;
  logic [WAY_W-1:0]          best_way_n;
  logic signed [COUNT_W-1:0] way0_count;
  logic signed [COUNT_W-1:0] way0_n;
  logic [WAY_W-1:0]          dway;
  logic                      last;
  logic                      hit_empty;
  logic                      beats;
  logic                      finish;
  logic [WAYS-1:0]           present;

  assign clearing = (state == ST_CLEAR);
  assign take     = (state == ST_IDLE) && !cmd_empty && !res_full;
  assign cmd_pop  = take;
  assign cmd_way  = WAY_W'(cmd.way);
  assign cmd_col  = COL_W'(cmd.column);

  // position of the commanded way in the order, the order is a permutation
  always_comb begin
    hit_pos = '0;
    for (int p = 0; p < WAYS; p++) begin
      if (order[p] == cmd_way) begin
        hit_pos = hit_pos | WAY_W'(p);
      end
    end
  end

  always_comb begin
    order_front[0] = cmd_way;
    for (int p = 1; p < WAYS; p++) begin
      order_front[p] = (WAY_W'(p) <= hit_pos) ? order[p-1] : order[p];
    end
    order_back[WAYS-1] = cmd_way;
    for (int p = 0; p < WAYS - 1; p++) begin
      order_back[p] = (WAY_W'(p) >= hit_pos) ? order[p+1] : order[p];
    end
  end

  // scan datapath, one way per cycle out of the count store read port
  assign dway      = order[scan_pos];
  assign last      = (scan_pos == WAY_W'(WAYS - 1));
  assign nxt_pos   = last ? scan_pos : scan_pos + 1'b1;
  assign hit_empty = (rd_data == COUNT_EMPTY);
  assign beats     = (rd_data > best);
  assign best_n    = beats ? rd_data : best;
  assign best_way_n = beats ? dway : best_way;
  assign way0_n    = (dway == '0) ? rd_data : way0_count;
  assign finish    = hit_empty || last;

  assign rd_pos  = (state == ST_SCAN) ? nxt_pos : '0;
  assign rd_addr = ADDR_W'(32'(col_ptr) * 32'(WAYS) + 32'(order[rd_pos]));

  assign mem_we  = clearing || (take && cmd.op == OP_WRITE);
  assign wr_addr = clearing ? clr_cnt
                            : ADDR_W'(32'(cmd_col) * 32'(WAYS) + 32'(cmd_way));
  assign wr_data = clearing ? COUNT_EMPTY : cmd.count;

  always_comb begin
    state_next   = state;
    order_next   = order;
    col_ptr_next = col_ptr;
    clr_cnt_next = clr_cnt;
    case (state)
      ST_CLEAR: begin
        clr_cnt_next = clr_cnt + 1'b1;
        if (clr_cnt == ADDR_W'(MEM_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (take) begin
          case (cmd.op)
            OP_FRONT:   order_next = order_front;
            OP_BACK:    order_next = order_back;
            OP_ADVANCE: col_ptr_next = (col_ptr == COL_W'(COLUMNS - 1)) ? '0
                                                                       : col_ptr + 1'b1;
            OP_RETREAT: col_ptr_next = (col_ptr == '0) ? COL_W'(COLUMNS - 1)
                                                       : col_ptr - 1'b1;
            OP_SELECT:  state_next = ST_SCAN;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (finish) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    res.current_column = COL_IN_W'(col_ptr_next);
    res.victim_way     = '0;
    res.victim_count   = '0;
    res_push           = 1'b0;
    if (take && cmd.op != OP_SELECT) begin
      res_push = 1'b1;
    end else if (state == ST_SCAN && finish) begin
      res_push = 1'b1;
      if (hit_empty) begin
        res.victim_way   = WAY_IN_W'(dway);
        res.victim_count = rd_data;
      end else begin
        // nothing above the floor means way 0 with its own count
        res.victim_way   = WAY_IN_W'(best_way_n);
        res.victim_count = (best_n != COUNT_FLOOR) ? best_n : way0_n;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      col_ptr <= '0;
      clr_cnt <= '0;
      for (int p = 0; p < WAYS; p++) begin
        order[p] <= WAY_W'(p);
      end
    end else begin
      state   <= state_next;
      col_ptr <= col_ptr_next;
      clr_cnt <= clr_cnt_next;
      order   <= order_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      scan_pos <= '0;
      best     <= COUNT_FLOOR;
      best_way <= '0;
    end else if (state == ST_SCAN) begin
      scan_pos   <= nxt_pos;
      best       <= best_n;
      best_way   <= best_way_n;
      way0_count <= way0_n;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // every way held somewhere in the order
  always_comb begin
    present = '0;
    for (int w = 0; w < WAYS; w++) begin
      for (int p = 0; p < WAYS; p++) begin
        if (order[p] == WAY_W'(w)) begin
          present[w] = 1'b1;
        end
      end
    end
  end

  `IVS_ASSERT_IMPLIES(a_clear_no_take, state == ST_CLEAR, !cmd_pop)
  `IVS_ASSERT_IMPLIES(a_push_has_room, res_push, !res_full)
  `IVS_ASSERT_IMPLIES(a_order_perm, state != ST_CLEAR, &present)
  `IVS_ASSERT_NEXT(a_select_scans, cmd_pop && cmd.op == OP_SELECT, state == ST_SCAN)

endmodule
